// ===== design/b64e_pkg.sv =====
package b64e_pkg;

   // Most characters that one input byte can produce: sym, sym, pad, pad, line feed.
   localparam int MaxChars = 5;
   localparam int LenWidth = $clog2(MaxChars + 1);
   localparam int PosWidth = $clog2(MaxChars);

   localparam logic [7:0] LineWidthReset = 8'd72;
   localparam logic [6:0] LfChar         = 7'd10;
   localparam logic [6:0] PadChar        = 7'd61;

   localparam logic [1:0] PhaseFirst  = 2'd0;
   localparam logic [1:0] PhaseSecond = 2'd1;
   localparam logic [1:0] PhaseThird  = 2'd2;

   typedef struct packed {
      logic [1:0] phase;
      logic [3:0] carry;
      logic [7:0] line_count;
   } enc_state_type;

   typedef struct packed {
      logic [MaxChars-1:0][6:0] chars;
      logic [LenWidth-1:0]      len;
      logic                     fin;
   } enc_result_type;

   // Maps a 6-bit value onto the standard base64 alphabet.
   function automatic logic [6:0] sym(input logic [5:0] v);
      logic [6:0] wide;
      logic [6:0] ch;
      wide = {1'b0, v};
      if (v < 6'd26) begin
         ch = wide + 7'd65;
      end else if (v < 6'd52) begin
         ch = wide + 7'd71;
      end else if (v < 6'd62) begin
         ch = wide - 7'd4;
      end else if (v == 6'd62) begin
         ch = 7'd43;
      end else begin
         ch = 7'd47;
      end
      return ch;
   endfunction

endpackage

// ===== design/b64e_encode.sv =====
module b64e_encode (
   input  b64e_pkg::enc_state_type  state_cur,
   input  logic [7:0]               data_byte,
   input  logic                     final_byte,
   input  logic [7:0]               line_width,
   output b64e_pkg::enc_state_type  state_next,
   output b64e_pkg::enc_result_type result
);

   logic [8:0] count_sum;
   logic       line_break;

   assign count_sum  = {1'b0, state_cur.line_count} + 9'd4;
   assign line_break = (count_sum >= {1'b0, line_width}) || count_sum[8];

   always_comb begin
      state_next   = state_cur;
      result.chars = '0;
      result.len   = b64e_pkg::LenWidth'(1);
      result.fin   = final_byte;
      case (state_cur.phase)
         b64e_pkg::PhaseSecond: begin
            result.chars[0]  = b64e_pkg::sym({state_cur.carry[1:0], data_byte[7:4]});
            state_next.carry = data_byte[3:0];
            state_next.phase = b64e_pkg::PhaseThird;
            if (final_byte) begin
               result.chars[1] = b64e_pkg::sym({data_byte[3:0], 2'b00});
               result.chars[2] = b64e_pkg::PadChar;
               result.chars[3] = b64e_pkg::LfChar;
               result.len      = b64e_pkg::LenWidth'(4);
            end
         end
         b64e_pkg::PhaseThird: begin
            result.chars[0]  = b64e_pkg::sym({state_cur.carry, data_byte[7:6]});
            result.chars[1]  = b64e_pkg::sym(data_byte[5:0]);
            result.chars[2]  = b64e_pkg::LfChar;
            state_next.carry = 4'd0;
            state_next.phase = b64e_pkg::PhaseFirst;
            // A line that is not broken after this group is never empty, so a
            // final byte always needs exactly one line feed here.
            result.len = (line_break || final_byte) ? b64e_pkg::LenWidth'(3)
                                                     : b64e_pkg::LenWidth'(2);
            state_next.line_count = line_break ? 8'd0 : count_sum[7:0];
         end
         default: begin
            result.chars[0]  = b64e_pkg::sym(data_byte[7:2]);
            state_next.carry = {2'b00, data_byte[1:0]};
            state_next.phase = b64e_pkg::PhaseSecond;
            if (final_byte) begin
               result.chars[1] = b64e_pkg::sym({data_byte[1:0], 4'b0000});
               result.chars[2] = b64e_pkg::PadChar;
               result.chars[3] = b64e_pkg::PadChar;
               result.chars[4] = b64e_pkg::LfChar;
               result.len      = b64e_pkg::LenWidth'(5);
            end
         end
      endcase
      if (final_byte) begin
         state_next = '0;
      end
   end

endmodule

// ===== design/b64e_outbuf.sv =====
module b64e_outbuf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  b64e_pkg::enc_result_type result,
   output logic                     can_load,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   logic [b64e_pkg::MaxChars-1:0][6:0] chars_ff;
   logic [b64e_pkg::LenWidth-1:0]      len_ff;
   logic                               fin_ff;
   logic [b64e_pkg::PosWidth-1:0]      pos_ff, pos_in;
   logic                               valid_ff, valid_in;
   logic                               last_char;
   logic                               take;

   assign last_char  = ({1'b0, pos_ff} + 1'b1) == {1'b0, len_ff};
   assign take       = valid_ff && rsp_tready;
   assign can_load   = !valid_ff || (rsp_tready && last_char);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, chars_ff[pos_ff]};
   assign rsp_tlast  = last_char;
   assign rsp_tuser  = last_char && fin_ff;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = '0;
      end else if (take && last_char) begin
         valid_in = 1'b0;
      end else if (take) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chars_ff <= result.chars;
         len_ff   <= result.len;
         fin_ff   <= result.fin;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, pos_ff} < len_ff) && (len_ff != '0))
      else $error("output position beyond buffered length");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (take && !last_char && !load) |=> valid_ff && (pos_ff == $past(pos_ff) + 1'b1))
      else $error("output position did not advance after a transaction");

   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff && (pos_ff == '0))
      else $error("new item did not restart the output buffer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || (take && last_char)))
      else $error("buffer loaded while characters were still pending");
`endif

endmodule

// ===== design/base64_stream_encoder.sv =====
// Streaming base64 encoder with the standard alphabet and line breaks. Message
// bytes arrive one per request transaction on req_tdata, with req_tlast set on
// the final byte; encoded ASCII characters leave one per response transaction.
// Each byte yields one character (two for the third byte of a group), a line
// feed follows any group that fills the line to csr_wdata characters (72 after
// reset), and the final byte adds a closing line feed and, if it leaves the
// group incomplete, the closing character and '=' padding, so one byte gives
// at most five characters. rsp_tlast marks the last character caused by each
// byte and rsp_tuser the last character of the whole message. The encoder
// takes one byte per cycle for as long as each byte yields a single character
// and the response port is ready; a byte that yields more characters holds
// the one-deep character buffer until all are taken, since the response port
// delivers one character per cycle. A new byte is accepted in the same cycle
// that the last character of the previous byte is taken. The line width
// register should only be written between transactions.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,    // line_width
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // final_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [6:0] out_char, [7] zero
   output logic       rsp_tlast,    // run_last
   output logic       rsp_tuser     // message_end
);

   // Line width register, written by the configuration port.
   logic [7:0] line_width_ff;

   // Group phase, leftover bits and characters on the current line.
   b64e_pkg::enc_state_type  state_ff, state_in;
   b64e_pkg::enc_result_type result;

   logic can_load;
   logic load;

   assign req_tready = can_load;
   assign load       = req_tvalid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= b64e_pkg::LineWidthReset;
      end else if (csr_we) begin
         line_width_ff <= csr_wdata;
      end
   end

   // The encoder works directly on the accepted byte and the current state;
   // its characters land in the output buffer in the same edge.
   b64e_encode u_encode (
      .state_cur  (state_ff),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .line_width (line_width_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

   b64e_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// One encoded character as it should leave the response port.
typedef struct packed {
   logic [6:0] ch;
   logic       run_last;
   logic       message_end;
} encoded_char_type;

// Tracks the encoder state and keeps the characters still owed by the design.
class base64_scoreboard;
   localparam logic [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [7:0]       line_width;
   logic [1:0]       phase;
   logic [3:0]       carry;
   logic [7:0]       line_count;
   encoded_char_type pending_chars[$];
   int               errors;

   function new();
      line_width = b64e_pkg::LineWidthReset;
      phase      = b64e_pkg::PhaseFirst;
      carry      = 4'd0;
      line_count = 8'd0;
      errors     = 0;
   endfunction

   function logic [6:0] b64(input logic [5:0] v);
      logic [7:0] c;
      c = Alphabet[8*(63 - int'(v)) +: 8];
      return c[6:0];
   endfunction

   // Works out the characters that one accepted byte produces.
   function void encode_byte(input logic [7:0] b, input logic fin);
      logic [6:0] chars [0:4];
      int         n;
      int         next_count;
      n = 0;
      if (phase == b64e_pkg::PhaseSecond) begin
         chars[0] = b64({carry[1:0], b[7:4]});
         carry    = b[3:0];
         phase    = b64e_pkg::PhaseThird;
         n        = 1;
         if (fin) begin
            chars[1] = b64({carry, 2'b00});
            chars[2] = b64e_pkg::PadChar;
            chars[3] = b64e_pkg::LfChar;
            n        = 4;
         end
      end else if (phase == b64e_pkg::PhaseThird) begin
         chars[0]   = b64({carry, b[7:6]});
         chars[1]   = b64(b[5:0]);
         phase      = b64e_pkg::PhaseFirst;
         carry      = 4'd0;
         n          = 2;
         next_count = int'(line_count) + 4;
         if (next_count >= int'(line_width) || next_count > 255) begin
            chars[2]   = b64e_pkg::LfChar;
            n          = 3;
            line_count = 8'd0;
         end else begin
            line_count = next_count[7:0];
         end
         if (fin && line_count != 8'd0) begin
            chars[n] = b64e_pkg::LfChar;
            n++;
         end
      end else begin
         chars[0] = b64(b[7:2]);
         carry    = {2'b00, b[1:0]};
         phase    = b64e_pkg::PhaseSecond;
         n        = 1;
         if (fin) begin
            chars[1] = b64({b[1:0], 4'b0000});
            chars[2] = b64e_pkg::PadChar;
            chars[3] = b64e_pkg::PadChar;
            chars[4] = b64e_pkg::LfChar;
            n        = 5;
         end
      end
      for (int i = 0; i < n; i++) begin
         pending_chars.push_back('{chars[i], i == n - 1, fin && i == n - 1});
      end
      if (fin) begin
         phase      = b64e_pkg::PhaseFirst;
         carry      = 4'd0;
         line_count = 8'd0;
      end
   endfunction

   task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // Compares one accepted response transaction with the oldest owed character.
   task check_char(input logic [7:0] data, input logic last, input logic user);
      encoded_char_type want;
      if (pending_chars.size() == 0) begin
         report($sformatf("character %h arrived with nothing owed", data));
      end else begin
         want = pending_chars.pop_front();
         if (data !== {1'b0, want.ch})
            report($sformatf("character %h, wanted %h", data, want.ch));
         if (last !== want.run_last)
            report($sformatf("tlast %b, wanted %b on %h", last, want.run_last, want.ch));
         if (user !== want.message_end)
            report($sformatf("tuser %b, wanted %b on %h", user, want.message_end, want.ch));
      end
   endtask
endclass

module tb;

   // The clock starts low so that the first rising edge falls at 4 ns.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   base64_scoreboard board = new();

   // While calm is set, neither side of the design sees any idle cycles.
   logic calm = 1'b0;
   int   bytes_sent = 0;
   int   msg_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   base64_stream_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The receiver stalls in about a quarter of the cycles unless calm is set.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 25);
   end

   // Both channels are sampled at the rising edge, before any of this edge's
   // nonblocking updates land. A request transaction is noted first so that
   // its characters are owed before any response of the same edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.encode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_char(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // Offers one byte and returns at the edge where the transaction completes.
   // tvalid is left high so that a following byte can go out back to back;
   // drain_encoder lowers it when the stream pauses.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (!calm && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Holds the sender off until every owed character has come out, then adds a
   // margin. The design may still be mid-message at this point.
   task automatic drain_encoder();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The line width is only changed while the encoder is quiet.
   task automatic set_line_width(input logic [7:0] w);
      drain_encoder();
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.line_width = w;
   endtask

   // Sends a run of random bytes. Message lengths are mostly short, with the
   // odd long one so that wide lines also fill up. A run may stop in the
   // middle of a message; the next run simply carries on with it.
   task automatic send_stream(input int count);
      for (int i = 0; i < count; i++) begin
         if (msg_left == 0)
            msg_left = ($urandom_range(5) == 0) ? $urandom_range(200, 60) : $urandom_range(12, 1);
         msg_left--;
         send_byte(8'($urandom_range(255)), msg_left == 0);
      end
   endtask

   initial begin
      int         phase_no;
      logic [7:0] width;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A one-byte message under the reset width: two symbols and two pads.
      send_byte(8'hFF, 1'b1);

      // Narrowest line: a line feed after every complete group. Messages of one,
      // two and three bytes end with two pads, one pad and no pad.
      set_line_width(8'd4);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);

      // Widest line: a full group leaves the line open, so a closing line feed
      // follows. The bytes hit the last two alphabet symbols.
      set_line_width(8'd252);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);

      // The width changes in the middle of a group and takes effect at the
      // next group check.
      send_byte(8'h14, 1'b0);
      send_byte(8'hFB, 1'b0);
      set_line_width(8'd8);
      send_byte(8'h9C, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'hD9, 1'b0);
      send_byte(8'h7E, 1'b1);

      // Random part: each run picks a line width, extremes included. The
      // fourth run goes without any idle cycles on either side.
      phase_no = 0;
      while (bytes_sent < 344) begin
         case ($urandom_range(3))
            0:       width = 8'd4;
            1:       width = 8'd252;
            2:       width = 8'($urandom_range(16, 5));
            default: width = 8'($urandom_range(252, 4));
         endcase
         calm = (phase_no == 3);
         set_line_width(width);
         send_stream($urandom_range(50, 15));
         phase_no++;
      end
      calm = 1'b0;

      drain_encoder();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending_chars.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // This timeout allows far more time than a correct run needs.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
